// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, transaction payload types, command encoding and the
// state type of the execution unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int TAB_WIDTH_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Widest coordinates any legal parameter set can produce.
    localparam int CMD_COL_W = 7;
    localparam int CMD_ROW_W = 6;

    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_LIN_W = 11;

    localparam logic [7:0] ATTR_RESET = 8'hF0;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] col_in;
        logic [7:0] row_in;
    } in_item_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] cursor_col;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_LIN_W-1:0] cursor_linear;
        logic [15:0]          cell_data;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_PRINT,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_TAB,
        CMD_CLEAR,
        CMD_SET,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [7:0]           ch;
        logic [CMD_COL_W-1:0] col;
        logic [CMD_ROW_W-1:0] row;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_READ
    } back_state_t;

endpackage

// ----- rtl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts request transactions, decodes them into commands with clamped
// coordinates and hands them to the command queue through a register.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             init_busy,
    input  logic             s_valid,
    output logic             s_ready,
    input  tcw_pkg::in_item_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output tcw_pkg::cmd_t    q_cmd
);

    localparam int CCW = tcw_pkg::CMD_COL_W;
    localparam int CRW = tcw_pkg::CMD_ROW_W;

    logic          f_valid_reg;
    logic          f_valid_next;
    tcw_pkg::cmd_t f_cmd_reg;
    tcw_pkg::cmd_t f_cmd_next;
    logic          accept;

    // No new transaction is taken while the store is being cleared after reset.
    assign s_ready = !init_busy && (!f_valid_reg || q_ready);
    assign accept  = s_valid && s_ready;
    assign q_valid = f_valid_reg;
    assign q_cmd   = f_cmd_reg;

    always_comb begin
        f_cmd_next      = f_cmd_reg;
        f_cmd_next.kind = tcw_pkg::CMD_PRINT;
        f_cmd_next.ch   = s_data.char_code;
        f_cmd_next.col  = (s_data.col_in >= 8'(COLUMNS)) ? CCW'(COLUMNS - 1)
                                                         : s_data.col_in[CCW-1:0];
        f_cmd_next.row  = (s_data.row_in >= 8'(ROWS)) ? CRW'(ROWS - 1)
                                                      : s_data.row_in[CRW-1:0];
        case (s_data.req_type)
            tcw_pkg::REQ_PUT: begin
                if (s_data.char_code == tcw_pkg::CH_NEWLINE) begin
                    f_cmd_next.kind = tcw_pkg::CMD_NEWLINE;
                end else if (s_data.char_code == tcw_pkg::CH_RETURN) begin
                    f_cmd_next.kind = tcw_pkg::CMD_RETURN;
                end else if (s_data.char_code == tcw_pkg::CH_TAB) begin
                    f_cmd_next.kind = tcw_pkg::CMD_TAB;
                end else begin
                    f_cmd_next.kind = tcw_pkg::CMD_PRINT;
                end
            end
            tcw_pkg::REQ_CLEAR: f_cmd_next.kind = tcw_pkg::CMD_CLEAR;
            tcw_pkg::REQ_SET:   f_cmd_next.kind = tcw_pkg::CMD_SET;
            tcw_pkg::REQ_READ:  f_cmd_next.kind = tcw_pkg::CMD_READ;
            default:            f_cmd_next.kind = tcw_pkg::CMD_PRINT;
        endcase
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (q_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_cmd_reg <= f_cmd_next;
        end
    end

endmodule

// ----- rtl/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short first-in first-out buffer that decouples decoding from execution.
// ----------------------------------------------------------------------------
module tcw_queue #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcw_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_pop,
    output tcw_pkg::cmd_t out_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    tcw_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// Text console writer execution unit
// Holds the cell store, the cursor and the attribute register, carries out
// queued commands and drives the result register. Scrolling rotates the
// row origin of the store and blanks the row that becomes the bottom line.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               q_valid,
    output logic               q_pop,
    input  tcw_pkg::cmd_t      q_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::out_item_t m_data,
    output logic               init_busy
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int OCW   = tcw_pkg::OUT_COL_W;
    localparam int ORW   = tcw_pkg::OUT_ROW_W;
    localparam int OLW   = tcw_pkg::OUT_LIN_W;

    tcw_pkg::back_state_t state_reg;
    tcw_pkg::back_state_t state_next;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [RW-1:0] top_reg;
    logic [RW-1:0] top_next;
    logic [AW-1:0] top_base_reg;
    logic [AW-1:0] top_base_next;
    logic [AW-1:0] fill_addr_reg;
    logic [AW-1:0] fill_addr_next;
    logic [AW-1:0] fill_last_reg;
    logic [AW-1:0] fill_last_next;
    logic [15:0]   fill_data_reg;
    logic [15:0]   fill_data_next;
    logic [7:0]    attr_reg;
    logic [7:0]    attr_next;

    logic               m_valid_reg;
    logic               m_valid_next;
    tcw_pkg::out_item_t m_data_reg;
    tcw_pkg::out_item_t m_data_next;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          rd_en;

    // Constant table of tab stops, one entry per column.
    logic [CW-1:0] tab_col [COLUMNS];
    logic          tab_wrap [COLUMNS];

    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [RW:0]   phys_sum;
    logic [RW-1:0] phys_row;
    logic [AW-1:0] cell_addr;

    logic          out_free;
    logic          emit;
    logic [15:0]   emit_data;
    logic          is_put;
    logic [CW-1:0] step_col;
    logic          step_wrap;
    logic          step_adv;
    logic [AW-1:0] lin;

    for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
        localparam int STOP = (g / TAB_WIDTH + 1) * TAB_WIDTH;
        assign tab_wrap[g] = (STOP >= COLUMNS);
        assign tab_col[g]  = (STOP >= COLUMNS) ? '0 : CW'(STOP);
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign init_busy = (state_reg == tcw_pkg::ST_INIT);

    // Logical row to store address, through the rotating row origin.
    assign sel_row   = (q_cmd.kind == tcw_pkg::CMD_READ) ? q_cmd.row[RW-1:0] : row_reg;
    assign sel_col   = (q_cmd.kind == tcw_pkg::CMD_READ) ? q_cmd.col[CW-1:0] : col_reg;
    assign phys_sum  = {1'b0, sel_row} + {1'b0, top_reg};
    assign phys_row  = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                                   : phys_sum[RW-1:0];
    assign cell_addr = AW'(AW'(phys_row) * AW'(COLUMNS)) + AW'(sel_col);

    assign attr_next = cfg_wr_en ? cfg_wr_data : attr_reg;
    assign lin       = AW'(AW'(row_next) * AW'(COLUMNS)) + AW'(col_next);

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        top_base_next  = top_base_reg;
        fill_addr_next = fill_addr_reg;
        fill_last_next = fill_last_reg;
        fill_data_next = fill_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_addr_reg;
        mem_wdata      = fill_data_reg;
        rd_en          = 1'b0;
        q_pop          = 1'b0;
        emit           = 1'b0;
        emit_data      = '0;
        is_put         = 1'b0;
        step_col       = col_reg;
        step_wrap      = 1'b0;
        step_adv       = 1'b0;

        case (state_reg)
            tcw_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CHAR};
                if (fill_addr_reg == AW'(CELLS - 1)) begin
                    state_next = tcw_pkg::ST_IDLE;
                end else begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        tcw_pkg::CMD_PRINT: begin
                            is_put    = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr;
                            mem_wdata = {attr_reg, q_cmd.ch};
                            step_col  = col_reg + 1'b1;
                            step_wrap = (col_reg == CW'(COLUMNS - 1));
                        end
                        tcw_pkg::CMD_NEWLINE: begin
                            is_put   = 1'b1;
                            step_col = '0;
                            step_adv = 1'b1;
                        end
                        tcw_pkg::CMD_RETURN: begin
                            is_put   = 1'b1;
                            step_col = '0;
                        end
                        tcw_pkg::CMD_TAB: begin
                            is_put    = 1'b1;
                            step_col  = tab_col[col_reg];
                            step_wrap = tab_wrap[col_reg];
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            col_next       = '0;
                            row_next       = '0;
                            top_next       = '0;
                            top_base_next  = '0;
                            fill_addr_next = '0;
                            fill_last_next = AW'(CELLS - 1);
                            fill_data_next = {attr_reg, tcw_pkg::BLANK_CHAR};
                            state_next     = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::CMD_SET: begin
                            col_next = q_cmd.col[CW-1:0];
                            row_next = q_cmd.row[RW-1:0];
                            emit     = 1'b1;
                        end
                        tcw_pkg::CMD_READ: begin
                            rd_en      = 1'b1;
                            state_next = tcw_pkg::ST_READ;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase

                    if (is_put) begin
                        col_next = step_wrap ? '0 : step_col;
                        if (step_adv || step_wrap) begin
                            if (row_reg == RW'(ROWS - 1)) begin
                                // Bottom overflow: the top physical row becomes
                                // the new bottom line and is blanked.
                                fill_addr_next = top_base_reg;
                                fill_last_next = top_base_reg + AW'(COLUMNS - 1);
                                fill_data_next = {attr_reg, tcw_pkg::BLANK_CHAR};
                                if (top_reg == RW'(ROWS - 1)) begin
                                    top_next      = '0;
                                    top_base_next = '0;
                                end else begin
                                    top_next      = top_reg + 1'b1;
                                    top_base_next = top_base_reg + AW'(COLUMNS);
                                end
                                state_next = tcw_pkg::ST_FILL;
                            end else begin
                                row_next = row_reg + 1'b1;
                                emit     = 1'b1;
                            end
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
            end
            tcw_pkg::ST_FILL: begin
                mem_we = 1'b1;
                if (fill_addr_reg == fill_last_reg) begin
                    emit       = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end else begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            tcw_pkg::ST_READ: begin
                emit       = 1'b1;
                emit_data  = rdata_reg;
                state_next = tcw_pkg::ST_IDLE;
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next              = 1'b1;
            m_data_next.cursor_col    = OCW'(col_next);
            m_data_next.cursor_row    = ORW'(row_next);
            m_data_next.cursor_linear = OLW'(lin);
            m_data_next.cell_data     = emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcw_pkg::ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            top_base_reg  <= '0;
            fill_addr_reg <= '0;
            fill_last_reg <= AW'(CELLS - 1);
            attr_reg      <= tcw_pkg::ATTR_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            top_base_reg  <= top_base_next;
            fill_addr_reg <= fill_addr_next;
            fill_last_reg <= fill_last_next;
            attr_reg      <= attr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_data_reg <= fill_data_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[cell_addr];
        end
    end

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Put character, newline, return, tab and set cursor: result passes the front
// register, queue and result register, up to one transaction per cycle while no
// stall, scroll or clear holds it; read cell: result also passes the store read
// register, and no new command is taken in the read state. Scroll and clear
// screen are written cell by cell through the single write port of the cell store.
// After reset the store is cleared with s_ready low.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS        = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH   = tcw_pkg::TAB_WIDTH_DEF,
    parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcw_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);

    logic          init_busy;
    logic          fq_valid;
    logic          fq_ready;
    tcw_pkg::cmd_t fq_cmd;
    logic          qb_valid;
    logic          qb_pop;
    tcw_pkg::cmd_t qb_cmd;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_busy (init_busy),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_cmd     (fq_cmd)
    );

    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_cmd   (qb_cmd)
    );

    tcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (qb_valid),
        .q_pop       (qb_pop),
        .q_cmd       (qb_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .init_busy   (init_busy)
    );

endmodule

// ----- rtl/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level properties of the console writer, attached by a bind statement.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tcw_pkg::out_item_t m_data
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The reported cursor always lies on the screen.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cursor_col) < COLUMNS) && (int'(m_data.cursor_row) < ROWS))
        else $error("cursor outside the screen");

    // The linear cursor address agrees with row and column.
    a_linear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (ROWS > 32) || (m_data.cursor_linear ==
            11'(m_data.cursor_row * COLUMNS + m_data.cursor_col)))
        else $error("linear cursor mismatch");

    // The store is still being cleared in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("activity directly after reset");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/console_checker.sv -----
// ----------------------------------------------------------------------------
// Text console checker
// Watches both channels and the attribute port, keeps a shadow copy of the
// cell store, cursor and attribute, predicts each result and compares it
// field by field with the result the block returns.
// ----------------------------------------------------------------------------
module console_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  tcw_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  tcw_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int COLS  = tcw_pkg::COLUMNS_DEF;
    localparam int LINES = tcw_pkg::ROWS_DEF;
    localparam int TABW  = tcw_pkg::TAB_WIDTH_DEF;
    localparam int CELLS = COLS * LINES;
    localparam int AW    = $clog2(CELLS);

    logic [15:0]        shadow_cells [CELLS];
    int                 cur_x;
    int                 cur_y;
    logic [7:0]         attr;
    tcw_pkg::out_item_t awaited_results [$];

    task automatic blank_cells(input int first, input int count);
        for (int i = first; i < first + count; i++) begin
            shadow_cells[AW'(i)] = {attr, tcw_pkg::BLANK_CHAR};
        end
    endtask

    function automatic int clamp_coord(input logic [7:0] v, input int lim);
        return (int'(v) >= lim) ? lim - 1 : int'(v);
    endfunction

    // Applies one request to the shadow console and returns the result the
    // block should produce for it.
    task automatic advance_console(input tcw_pkg::in_item_t req,
                                   output tcw_pkg::out_item_t res);
        logic [15:0] cell_word;
        int          lin;
        cell_word = '0;
        case (req.req_type)
            tcw_pkg::REQ_PUT: begin
                case (req.char_code)
                    tcw_pkg::CH_NEWLINE: begin
                        cur_x = 0;
                        cur_y++;
                    end
                    tcw_pkg::CH_RETURN: begin
                        cur_x = 0;
                    end
                    tcw_pkg::CH_TAB: begin
                        cur_x = cur_x + TABW - (cur_x % TABW);
                    end
                    default: begin
                        shadow_cells[AW'(cur_y * COLS + cur_x)] = {attr, req.char_code};
                        cur_x++;
                    end
                endcase
                if (cur_x >= COLS) begin
                    cur_x = 0;
                    cur_y++;
                end
                // Running off the bottom scrolls everything up by one line.
                if (cur_y >= LINES) begin
                    for (int i = 0; i < CELLS - COLS; i++) begin
                        shadow_cells[AW'(i)] = shadow_cells[AW'(i + COLS)];
                    end
                    blank_cells(CELLS - COLS, COLS);
                    cur_y = LINES - 1;
                end
            end
            tcw_pkg::REQ_CLEAR: begin
                blank_cells(0, CELLS);
                cur_x = 0;
                cur_y = 0;
            end
            tcw_pkg::REQ_SET: begin
                cur_x = clamp_coord(req.col_in, COLS);
                cur_y = clamp_coord(req.row_in, LINES);
            end
            default: begin
                cell_word = shadow_cells[AW'(clamp_coord(req.row_in, LINES) * COLS
                                             + clamp_coord(req.col_in, COLS))];
            end
        endcase
        lin = cur_y * COLS + cur_x;
        res.cursor_col    = cur_x[tcw_pkg::OUT_COL_W-1:0];
        res.cursor_row    = cur_y[tcw_pkg::OUT_ROW_W-1:0];
        res.cursor_linear = lin[tcw_pkg::OUT_LIN_W-1:0];
        res.cell_data     = cell_word;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        tcw_pkg::out_item_t want;
        tcw_pkg::out_item_t predicted;
        if (!aresetn) begin
            attr = tcw_pkg::ATTR_RESET;
            cur_x = 0;
            cur_y = 0;
            blank_cells(0, CELLS);
            awaited_results.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual 'h%0h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("cursor_col", int'(want.cursor_col),
                                int'(m_data.cursor_col));
                    check_field("cursor_row", int'(want.cursor_row),
                                int'(m_data.cursor_row));
                    check_field("cursor_linear", int'(want.cursor_linear),
                                int'(m_data.cursor_linear));
                    check_field("cell_data", int'(want.cell_data),
                                int'(m_data.cell_data));
                end
            end
            if (s_valid && s_ready) begin
                advance_console(s_data, predicted);
                awaited_results.push_back(predicted);
            end
            if (cfg_wr_en) begin
                attr = cfg_wr_data;
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives directed and random console requests through several phases of
// sender and receiver idling and attribute settings, and reports the verdict
// from the checker's mismatch count and its queue of awaited results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int STALL_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 20;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    tcw_pkg::in_item_t  s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    tcw_pkg::out_item_t m_data;
    logic               cfg_wr_en   = 1'b0;
    logic [7:0]         cfg_wr_data = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int mismatches;
    int outstanding;

    always #5 aclk = ~aclk;

    text_console_writer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    console_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // The reset clearing pass and a clear screen both hold s_ready low for a
    // full store walk, so the limit is well above that.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("text_console_writer verification failed");
            $finish;
        end
    end

    function automatic tcw_pkg::in_item_t mk_req(input logic [1:0] kind,
                                                 input logic [7:0] ch,
                                                 input logic [7:0] col,
                                                 input logic [7:0] row);
        tcw_pkg::in_item_t r;
        r = {kind, ch, col, row};
        return r;
    endfunction

    // Mostly a stream of text with control characters, plus cursor moves,
    // cell reads aimed mainly at the screen and the odd clear.
    function automatic tcw_pkg::in_item_t random_request();
        tcw_pkg::in_item_t r;
        int                pick;
        int                glyph;
        r.char_code = 8'($urandom_range(255));
        r.col_in    = 8'($urandom_range(255));
        r.row_in    = 8'($urandom_range(255));
        pick        = $urandom_range(999);
        if (pick < 10) begin
            r.req_type = tcw_pkg::REQ_CLEAR;
        end else if (pick < 230) begin
            r.req_type = (pick < 90) ? tcw_pkg::REQ_SET : tcw_pkg::REQ_READ;
            if ($urandom_range(3) != 0) begin
                r.col_in = 8'($urandom_range(tcw_pkg::COLUMNS_DEF - 1));
                r.row_in = 8'($urandom_range(tcw_pkg::ROWS_DEF - 1));
            end
        end else begin
            r.req_type = tcw_pkg::REQ_PUT;
            glyph      = $urandom_range(99);
            if (glyph < 8) begin
                r.char_code = tcw_pkg::CH_NEWLINE;
            end else if (glyph < 11) begin
                r.char_code = tcw_pkg::CH_RETURN;
            end else if (glyph < 16) begin
                r.char_code = tcw_pkg::CH_TAB;
            end else if (glyph < 70) begin
                r.char_code = 8'($urandom_range(8'h7E, 8'h20));
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(input tcw_pkg::in_item_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_directed();
        send_req(mk_req(tcw_pkg::REQ_READ, 8'h00, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'h41, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'h00, 8'hFF, 8'hFF));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'hFF, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'h0F, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'h0E, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_RETURN, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_READ, 8'h00, 8'd2, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_READ, 8'h00, 8'hFF, 8'hFF));
        // A character in the last cell wraps and scrolls the screen.
        send_req(mk_req(tcw_pkg::REQ_SET, 8'h00, 8'hFF, 8'hFF));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'h80, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_READ, 8'h00, 8'd79, 8'd23));
        send_req(mk_req(tcw_pkg::REQ_SET, 8'h00, 8'd78, 8'd24));
        send_req(mk_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_SET, 8'h00, 8'd79, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_PUT, 8'h78, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_SET, 8'h00, 8'd5, 8'd24));
        send_req(mk_req(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_READ, 8'h00, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_CLEAR, 8'h00, 8'd0, 8'd0));
        send_req(mk_req(tcw_pkg::REQ_READ, 8'h00, 8'd10, 8'd10));
        send_req(mk_req(tcw_pkg::REQ_SET, 8'h00, 8'd79, 8'd24));
    endtask

    initial begin
        logic [7:0] attr_value;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 58;
                end
                default: begin
                    send_idle_pct = 25;
                    stall_pct     = 25;
                end
            endcase
            if (phase == 0) begin
                run_directed();
            end else begin
                case (phase)
                    1:       attr_value = 8'h00;
                    2:       attr_value = 8'hFF;
                    4:       attr_value = 8'h0F;
                    7:       attr_value = tcw_pkg::ATTR_RESET;
                    default: attr_value = 8'($urandom_range(255));
                endcase
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= attr_value;
                @(negedge aclk);
                cfg_wr_en   <= 1'b0;
            end
            repeat (RANDOM_PER_PHASE) send_req(random_request());
            s_valid <= 1'b0;
            while (outstanding != 0) @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("text_console_writer verification clean");
        end else begin
            $display("text_console_writer verification failed");
        end
        $finish;
    end

endmodule
